// ===== rtl/stt_pkg.sv =====
// shared types and constants for the timed task table
// no dependencies
package stt_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int TICK_W = 32;
    localparam int PERIOD_W = 16;
    localparam int ID_W = 8;
    localparam int DIV_CNT_W = $clog2(TICK_W + 1);

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_BAD_ID = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
        logic                periodic;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } wr_port_t;

    typedef struct packed {
        logic                start;
        logic [TICK_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_DIV,
        ST_FIRE,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_NEXT,
        ST_FIN
    } state_t;

endpackage

// ===== rtl/software_timer_task_table.sv =====
// top level of the timed task table: request sequencer and result register
// depends on stt_pkg, stt_table and stt_mod_unit
//
// Each request is one transfer in and yields one or more result transfers,
// the final one with m_tlast. Start requests, and stops and ticks on an
// empty table, finish without a scan; a stop scans the occupied slots from
// the highest down and moves the last entry into each slot whose id
// matches. A tick scans the occupied slots from the highest down and runs a
// 32-step serial remainder of the tick count by each nonzero period in the
// single shared remainder unit. A fired one-shot task is then replaced by
// the last entry, moved into its slot. s_tready is high only while no
// request is in progress.
module software_timer_task_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // task_id[7:0], period_ticks[23:8], periodic[24]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[1:0], fired_id[9:2]
    output logic        m_tuser,   // fired
    output logic        m_tlast
);
    import stt_pkg::*;

    state_t               state_reg, state_next;
    logic [1:0]           req_reg, req_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [1:0]           status_reg, status_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [ID_W-1:0]      pend_id_reg, pend_id_next;
    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_status_reg, m_status_next;
    logic                 m_fired_reg, m_fired_next;
    logic [ID_W-1:0]      m_id_reg, m_id_next;
    logic                 m_last_reg, m_last_next;

    wr_port_t             wr;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    entry_t               rd_data;
    div_req_t             div_req;
    div_res_t             div_res;
    logic                 out_free;
    logic                 s_take;
    logic [IDX_W-1:0]     last_idx;
    entry_t               s_entry;

    stt_table u_table (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stt_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .res     (div_res)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_take   = s_tvalid && s_tready;
    assign last_idx = IDX_W'(count_reg - 1'b1);
    assign s_entry  = '{id: s_tdata[7:0], period: s_tdata[23:8], periodic: s_tdata[24]};

    always_comb begin
        state_next       = state_reg;
        req_next         = req_reg;
        id_next          = id_reg;
        status_next      = status_reg;
        count_next       = count_reg;
        tick_next        = tick_reg;
        idx_next         = idx_reg;
        pend_next        = pend_reg;
        pend_id_next     = pend_id_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_fired_next     = m_fired_reg;
        m_id_next        = m_id_reg;
        m_last_next      = m_last_reg;
        wr               = '0;
        rd_en            = 1'b0;
        rd_addr          = idx_reg;
        div_req.start    = 1'b0;
        div_req.dividend = tick_reg;
        div_req.divisor  = rd_data.period;

        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    req_next    = s_tuser;
                    id_next     = s_tdata[7:0];
                    status_next = STAT_OK;
                    idx_next    = last_idx;
                    state_next  = ST_FIN;
                    if (s_tuser == REQ_TICK) begin
                        tick_next = tick_reg + 1'b1;
                        if (count_reg == '0) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            state_next = ST_RD;
                        end
                    end else if (s_tuser == REQ_START) begin
                        if (s_tdata[7:0] == '0) begin
                            status_next = STAT_BAD_ID;
                        end else if (count_reg >= CNT_W'(TABLE_DEPTH)) begin
                            status_next = STAT_FULL;
                        end else begin
                            wr.en      = 1'b1;
                            wr.addr    = IDX_W'(count_reg);
                            wr.data    = s_entry;
                            count_next = count_reg + 1'b1;
                        end
                    end else if (s_tuser == REQ_STOP) begin
                        if (s_tdata[7:0] == '0) begin
                            status_next = STAT_BAD_ID;
                        end else if (count_reg == '0) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            state_next = ST_RD;
                        end
                    end
                end
            end
            ST_RD: begin
                rd_en      = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                state_next = ST_NEXT;
                if (req_reg == REQ_TICK) begin
                    if (rd_data.period != '0) begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end else if (rd_data.id == id_reg) begin
                    state_next = ST_MOVE_RD;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    state_next = div_res.rem_zero ? ST_FIRE : ST_NEXT;
                end
            end
            ST_FIRE: begin
                if (!pend_reg || out_free) begin
                    if (pend_reg) begin
                        m_valid_next  = 1'b1;
                        m_status_next = STAT_OK;
                        m_fired_next  = 1'b1;
                        m_id_next     = pend_id_reg;
                        m_last_next   = 1'b0;
                    end
                    pend_next    = 1'b1;
                    pend_id_next = rd_data.id;
                    state_next   = rd_data.periodic ? ST_NEXT : ST_MOVE_RD;
                end
            end
            ST_MOVE_RD: begin
                rd_en      = 1'b1;
                rd_addr    = last_idx;
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                wr.en      = 1'b1;
                wr.addr    = idx_reg;
                wr.data    = rd_data;
                count_next = count_reg - 1'b1;
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                if (idx_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_fired_next  = pend_reg;
                    m_id_next     = pend_reg ? pend_id_reg : '0;
                    m_last_next   = 1'b1;
                    pend_next     = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            tick_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            tick_reg    <= tick_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg      <= req_next;
        id_reg       <= id_next;
        status_reg   <= status_next;
        idx_reg      <= idx_next;
        pend_id_reg  <= pend_id_next;
        m_status_reg <= m_status_next;
        m_fired_reg  <= m_fired_next;
        m_id_reg     <= m_id_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_id_reg, m_status_reg};
    assign m_tuser  = m_fired_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_reg)
        else $error("pending firing left behind");
    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> state_reg == ST_DIV)
        else $error("remainder result outside wait state");
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHK |-> CNT_W'(idx_reg) < count_reg)
        else $error("scan index past occupied slots");
    a_tick_step: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_reg != $past(tick_reg) |-> $past(s_take) && $past(s_tuser) == REQ_TICK)
        else $error("tick count moved without a tick");
`endif

endmodule

// ===== rtl/stt_mod_unit.sv =====
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on stt_pkg
module stt_mod_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  stt_pkg::div_req_t req,
    output stt_pkg::div_res_t res
);
    import stt_pkg::*;

    logic [TICK_W-1:0]    dvd_reg, dvd_next;
    logic [PERIOD_W-1:0]  dsr_reg, dsr_next;
    logic [PERIOD_W-1:0]  rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [PERIOD_W:0]    trial;

    always_comb begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[TICK_W-1]};
        if (req.start) begin
            dvd_next = req.dividend;
            dsr_next = req.divisor;
            rem_next = '0;
            cnt_next = DIV_CNT_W'(TICK_W);
        end else if (cnt_reg != '0) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = PERIOD_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[PERIOD_W-1:0];
            end
            dvd_next  = {dvd_reg[TICK_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign res.done     = done_reg;
    assign res.rem_zero = (rem_reg == '0);

`ifndef SYNTHESIS
    a_done_after_last_step: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> cnt_reg == '0)
        else $error("remainder done while steps remain");
    a_step_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0 && !req.start) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("step counter skipped");
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> rem_reg < dsr_reg)
        else $error("remainder not reduced");
`endif

endmodule

// ===== rtl/stt_table.sv =====
// task entry store, one write port and one registered read port
// depends on stt_pkg
module stt_table (
    input  logic                    aclk,
    input  stt_pkg::wr_port_t       wr,
    input  logic                    rd_en,
    input  logic [stt_pkg::IDX_W-1:0] rd_addr,
    output stt_pkg::entry_t         rd_data
);
    import stt_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== bench/tb_software_timer_task_table.sv =====
// self-checking testbench for the timed task table: directed and random requests
// checks every result transfer against a cycle-free model of the table kept here
// depends on stt_pkg and software_timer_task_table
module tb_software_timer_task_table;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 186;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]          kind;
        logic [ID_W-1:0]     task_id;
        logic [PERIOD_W-1:0] period;
        logic                periodic;
        bit                  wait_idle;
    } request_t;

    typedef struct {
        logic [1:0]      status;
        logic            fired;
        logic [ID_W-1:0] fired_id;
        logic            last;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    request_t req_queue[$];
    result_t  exp_results[$];
    request_t cur_req;

    entry_t      tbl[TABLE_DEPTH];
    int          used_slots = 0;
    bit [31:0]   tick_cnt = '0;

    int     accepted_cnt = 0;
    int     err_cnt = 0;
    int     cycle_cnt = 0;
    int     send_gap = 0;
    bit     send_burst = 1'b0;
    int     recv_stall = 0;
    bit     recv_burst = 1'b0;
    bit     hold_done = 1'b0;

    software_timer_task_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    function automatic void add_req(logic [1:0] kind, int id, int period, int periodic,
                                    bit wait_idle = 1'b0);
        request_t r;
        r.kind = kind;
        r.task_id = id[ID_W-1:0];
        r.period = period[PERIOD_W-1:0];
        r.periodic = periodic[0];
        r.wait_idle = wait_idle;
        req_queue.push_back(r);
    endfunction

    function automatic void push_result(logic [1:0] status, logic fired,
                                        logic [ID_W-1:0] id, logic last);
        result_t res;
        res.status = status;
        res.fired = fired;
        res.fired_id = id;
        res.last = last;
        exp_results.push_back(res);
    endfunction

    function automatic void drop_entry(int k);
        tbl[k] = tbl[used_slots-1];
        used_slots--;
    endfunction

    // advances the table copy by one request and queues the results it causes
    function automatic void apply_request(request_t r);
        int k;
        int fire_cnt;
        result_t tail;
        fire_cnt = 0;
        case (r.kind)
            REQ_TICK: begin
                tick_cnt = tick_cnt + 1;
                if (used_slots == 0) begin
                    push_result(STAT_EMPTY, 1'b0, '0, 1'b1);
                end else begin
                    for (k = used_slots - 1; k >= 0; k--) begin
                        if (k < used_slots && tbl[k].period != 0 &&
                            (tick_cnt % {16'd0, tbl[k].period}) == 0) begin
                            push_result(STAT_OK, 1'b1, tbl[k].id, 1'b0);
                            fire_cnt++;
                            if (!tbl[k].periodic)
                                drop_entry(k);
                        end
                    end
                    if (fire_cnt == 0) begin
                        push_result(STAT_OK, 1'b0, '0, 1'b1);
                    end else begin
                        tail = exp_results[$];
                        tail.last = 1'b1;
                        exp_results[$] = tail;
                    end
                end
            end
            REQ_START: begin
                if (r.task_id == 0) begin
                    push_result(STAT_BAD_ID, 1'b0, '0, 1'b1);
                end else if (used_slots >= TABLE_DEPTH) begin
                    push_result(STAT_FULL, 1'b0, '0, 1'b1);
                end else begin
                    tbl[used_slots].id = r.task_id;
                    tbl[used_slots].period = r.period;
                    tbl[used_slots].periodic = r.periodic;
                    used_slots++;
                    push_result(STAT_OK, 1'b0, '0, 1'b1);
                end
            end
            REQ_STOP: begin
                if (r.task_id == 0) begin
                    push_result(STAT_BAD_ID, 1'b0, '0, 1'b1);
                end else if (used_slots == 0) begin
                    push_result(STAT_EMPTY, 1'b0, '0, 1'b1);
                end else begin
                    for (k = used_slots - 1; k >= 0; k--) begin
                        if (k < used_slots && tbl[k].id == r.task_id)
                            drop_entry(k);
                    end
                    push_result(STAT_OK, 1'b0, '0, 1'b1);
                end
            end
            default: begin
                push_result(STAT_OK, 1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic int draw_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        if (r < 15)
            return $urandom_range(1, 255);
        return $urandom_range(1, 6);
    endfunction

    function automatic int draw_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        if (r < 12)
            return $urandom_range(0, 65535);
        if (r < 15)
            return 65535;
        return $urandom_range(1, 12);
    endfunction

    function automatic void add_random(logic [1:0] kind, bit wait_idle = 1'b0);
        if (kind == REQ_TICK)
            add_req(kind, $urandom_range(0, 255), $urandom_range(0, 65535),
                    $urandom_range(0, 1), wait_idle);
        else
            add_req(kind, draw_id(), draw_period(), $urandom_range(0, 1), wait_idle);
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(cur_req);
                accepted_cnt++;
                if ($urandom_range(0, 15) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 12);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (req_queue.size() > 0 &&
                             !(req_queue[0].wait_idle && exp_results.size() > 0)) begin
                    cur_req = req_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, cur_req.periodic, cur_req.period, cur_req.task_id};
                    s_tuser <= cur_req.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and result check
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (exp_results.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected transfer: status %0d fired %0b id %0d last %0b",
                                 m_tdata[1:0], m_tuser, m_tdata[9:2], m_tlast);
                end else begin
                    want = exp_results.pop_front();
                    if (m_tdata[1:0] !== want.status || m_tuser !== want.fired ||
                        m_tdata[9:2] !== want.fired_id || m_tlast !== want.last) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"mismatch: status %0d/%0d fired %0b/%0b ",
                                      "id %0d/%0d last %0b/%0b (expected/actual)"},
                                     want.status, m_tdata[1:0], want.fired, m_tuser,
                                     want.fired_id, m_tdata[9:2], want.last, m_tlast);
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 12);
            end
            if (!hold_done && accepted_cnt >= 60) begin
                hold_done = 1'b1;
                recv_stall = HOLD_CYCLES;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int n;
        int k;
        int i;
        add_req(REQ_TICK, 0, 0, 0);
        add_req(REQ_STOP, 5, 0, 0);
        add_req(REQ_START, 0, 7, 1);
        add_req(REQ_STOP, 0, 0, 0);
        add_req(REQ_START, 255, 65535, 1);
        add_req(REQ_START, 1, 0, 0);
        add_req(REQ_START, 2, 1, 0);
        add_req(REQ_START, 3, 2, 1);
        add_req(REQ_START, 3, 3, 0);
        add_req(REQ_TICK, 0, 0, 0);
        add_req(REQ_TICK, 255, 65535, 1);
        add_req(REQ_TICK, 0, 0, 0);
        add_req(REQ_UNUSED, 8'haa, 16'h5555, 1);
        add_req(REQ_STOP, 9, 0, 0);
        for (i = 0; i < 5; i++)
            add_req(REQ_START, 10 + i, 1, i % 2, i == 0);
        add_req(REQ_START, 15, 4, 1);
        add_req(REQ_TICK, 0, 0, 0, 1'b1);
        add_req(REQ_STOP, 3, 0, 0);
        add_req(REQ_STOP, 1, 0, 0);
        add_req(REQ_STOP, 255, 0, 0);

        // episodes: a few starts, a run of ticks, then stops, with some noise
        n = 0;
        while (n < RANDOM_ITEMS) begin
            k = $urandom_range(1, 5);
            for (i = 0; i < k; i++)
                add_random(REQ_START, i == 0 && $urandom_range(0, 3) == 0);
            n += k;
            k = $urandom_range(2, 10);
            for (i = 0; i < k; i++)
                add_random(REQ_TICK);
            n += k;
            k = $urandom_range(0, 2);
            for (i = 0; i < k; i++)
                add_random(REQ_STOP);
            n += k;
            if ($urandom_range(0, 3) == 0) begin
                add_random(2'($urandom_range(0, 3)));
                n++;
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_queue.size() > 0 || s_tvalid || exp_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_cnt == 0 && exp_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/stt_pkg.sv
rtl/stt_mod_unit.sv
rtl/stt_table.sv
rtl/software_timer_task_table.sv
bench/tb_software_timer_task_table.sv
